### rtl/core/lcv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-at camera view package
// Shared widths, operation and register codes, and saturation helper.
// ----------------------------------------------------------------------------
package lcv_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 32;
   localparam int AX_W      = FRAC_BITS + 2;
   localparam int VEC_W     = POS_W + AX_W;
   localparam int MUL_A_W   = VEC_W - FRAC_BITS + 1;
   localparam int MUL_B_W   = 32;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = 64;
   localparam int SCL_W     = 30;
   localparam int RAD_W     = 2 * SCL_W + 2;
   localparam int LEN_W     = RAD_W / 2;
   localparam int Q_W       = FRAC_BITS + 1;
   localparam int F_W       = FRAC_BITS + 3;
   localparam int RATE_W    = 17;
   localparam int GAIN_W    = 25;
   localparam int OP_W      = 3;
   localparam int IDX_W     = 3;
   localparam int ROW_W     = 2;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int RATE_RST  = (ONE + 25) / 50;
   localparam int GAIN_RST  = 2 << FRAC_BITS;

   typedef enum logic [OP_W-1:0] {
      OP_SET   = 3'd0,
      OP_GET   = 3'd1,
      OP_FWD   = 3'd2,
      OP_BWD   = 3'd3,
      OP_LEFT  = 3'd4,
      OP_RIGHT = 3'd5
   } op_type;

   typedef enum logic [IDX_W-1:0] {
      REG_TARGET_X = 3'd0,
      REG_TARGET_Y = 3'd1,
      REG_TARGET_Z = 3'd2,
      REG_UP_X     = 3'd3,
      REG_UP_Y     = 3'd4,
      REG_UP_Z     = 3'd5,
      REG_RATE     = 3'd6,
      REG_GAIN     = 3'd7
   } csr_reg_type;

   function automatic logic signed [POS_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if ((&v[ACC_W-1:POS_W-1]) || !(|v[ACC_W-1:POS_W-1])) begin
         r = v[POS_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/core/lcv_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiply with a registered product.
// ----------------------------------------------------------------------------
module lcv_mul
   import lcv_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic signed [MUL_A_W-1:0]   a,
   input  wire logic signed [MUL_B_W-1:0]   b,
   output logic signed [MUL_P_W-1:0]        p
);

   logic signed [MUL_P_W-1:0] p_ff;
   logic signed [MUL_P_W-1:0] p_in;

   assign p_in = MUL_P_W'(a) * MUL_P_W'(b);
   assign p    = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule
`default_nettype wire

### rtl/core/lcv_root.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer square root
// Bit-by-bit square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module lcv_root
   import lcv_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [RAD_W-1:0]   radicand,
   output logic                    done,
   output logic [LEN_W-1:0]        root
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RAD_W-1:0] rem_ff, rem_in;
   logic [RAD_W-1:0] res_ff, res_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic [RAD_W:0]   trial;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign done  = done_ff;
   assign root  = res_ff[LEN_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = {2'b01, {(RAD_W-2){1'b0}}};
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[RAD_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

endmodule
`default_nettype wire

### rtl/core/lcv_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring division of a scaled magnitude by the vector length, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcv_div
   import lcv_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [SCL_W-1:0]   num,
   input  wire logic [LEN_W-1:0]   den,
   output logic                    done,
   output logic [Q_W-1:0]          quo
);

   localparam int D_W   = SCL_W + FRAC_BITS;
   localparam int CNT_W = $clog2(Q_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] den_ff, den_in;
   logic [Q_W-1:0]   sh_ff, sh_in;
   logic [D_W-1:0]   dd;
   logic [LEN_W:0]   trial;

   assign dd    = {num, {FRAC_BITS{1'b0}}};
   assign trial = {rem_ff, sh_ff[Q_W-1]};
   assign done  = done_ff;
   assign quo   = sh_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      sh_in   = sh_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = LEN_W'(dd[D_W-1:Q_W]);
         den_in  = den;
         sh_in   = dd[Q_W-1:0];
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = LEN_W'(trial - {1'b0, den_ff});
            sh_in  = {sh_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[LEN_W-1:0];
            sh_in  = {sh_ff[Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
   end

endmodule
`default_nettype wire

### rtl/core/lookat_camera_view_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-at camera view unit
// Keeps a camera position and builds view matrix rows with one shared
// multiplier, an iterative square root and an iterative divider.
// ----------------------------------------------------------------------------
// Items arrive on the req_ channel with an operation code and a position
// used by the set operation. Only get-matrix produces results: three rsp_
// items, rows U, V and N, the last flagged by rsp_last_row. The csr_
// channel writes the target, up vector, move rate and strafe gain; it is
// always ready and should be written only while the block is idle.
// The block takes one item at a time and is not ready while it works.
// Set loads the position while idle; forward and backward scale it.
// Each normalisation makes one-bit scaling shifts, forms the sum of
// squares, takes the square root and runs three divides.
// Strafe needs one normalisation; get-matrix needs three, two cross
// products, three dot products and the row writes.
// Results leave through an output register; while the receiver stalls,
// the sequencer waits before writing the next row.
// Reset clears the position, loads the default registers and leaves the
// block idle with no result pending.
// ----------------------------------------------------------------------------
module lookat_camera_view_unit
   import lcv_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [OP_W-1:0]           req_op,
   input  wire logic signed [POS_W-1:0]   req_pos_x,
   input  wire logic signed [POS_W-1:0]   req_pos_y,
   input  wire logic signed [POS_W-1:0]   req_pos_z,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [ROW_W-1:0]               rsp_row_index,
   output logic signed [POS_W-1:0]        rsp_col0,
   output logic signed [POS_W-1:0]        rsp_col1,
   output logic signed [POS_W-1:0]        rsp_col2,
   output logic signed [POS_W-1:0]        rsp_col3,
   output logic                           rsp_last_row,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [IDX_W-1:0]          csr_index,
   input  wire logic [31:0]               csr_wdata
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DIFF  = 9'b000000010,
      S_ABS   = 9'b000000100,
      S_SCALE = 9'b000001000,
      S_MAC   = 9'b000010000,
      S_ROOT  = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_NEXT  = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   typedef enum logic [2:0] {
      K_CROSS  = 3'd0,
      K_SQ     = 3'd1,
      K_DOT    = 3'd2,
      K_MOVE   = 3'd3,
      K_STRAFE = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      D_N = 2'd0,
      D_U = 2'd1,
      D_V = 2'd2
   } dst_type;

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   kind_type   kind_ff, kind_in;
   dst_type    dst_ff, dst_in;
   logic       neg_ff, neg_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] didx_ff, didx_in;

   logic signed [POS_W-1:0] pos_ff [3];
   logic signed [POS_W-1:0] pos_in [3];
   logic signed [POS_W-1:0] tgt_ff [3];
   logic signed [POS_W-1:0] tgt_in [3];
   logic signed [POS_W-1:0] up_ff  [3];
   logic signed [POS_W-1:0] up_in  [3];
   logic [RATE_W-1:0]       rate_ff, rate_in;
   logic [GAIN_W-1:0]       gain_ff, gain_in;
   logic signed [VEC_W-1:0] vec_ff [3];
   logic signed [VEC_W-1:0] vec_in [3];
   logic [VEC_W-1:0]        mag_ff [3];
   logic [VEC_W-1:0]        mag_in [3];
   logic                    sgn_ff [3];
   logic                    sgn_in [3];
   logic signed [AX_W-1:0]  n_ff   [3];
   logic signed [AX_W-1:0]  n_in   [3];
   logic signed [AX_W-1:0]  u_ff   [3];
   logic signed [AX_W-1:0]  u_in   [3];
   logic signed [AX_W-1:0]  v_ff   [3];
   logic signed [AX_W-1:0]  v_in   [3];
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]        rsp_row_ff, rsp_row_in;
   logic signed [POS_W-1:0] rsp_col_ff [4];
   logic signed [POS_W-1:0] rsp_col_in [4];
   logic                    rsp_last_ff, rsp_last_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic signed [ACC_W-1:0]   pr;
   logic signed [ACC_W-1:0]   cv;
   logic signed [F_W-1:0]     fac;
   logic [2:0]                last_step;
   logic [2:0]                jstep;
   logic [1:0]                ci;
   logic [1:0]                cj;
   logic [1:0]                ci_raw;
   logic [1:0]                nx1;
   logic [1:0]                nx2;
   logic [VEC_W-1:0]          big;
   logic signed [AX_W-1:0]    ax_val;
   logic                      ax_we;
   logic                      ax_clr;
   logic [1:0]                dsel;

   logic             root_start;
   logic [RAD_W-1:0] root_rad;
   logic             root_done;
   logic [LEN_W-1:0] root_len;
   logic             div_start;
   logic             div_done;
   logic [Q_W-1:0]   div_quo;

   function automatic logic [1:0] next1(input logic [1:0] c);
      logic [1:0] r;
      case (c)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] next2(input logic [1:0] c);
      logic [1:0] r;
      case (c)
         2'd0:    r = 2'd2;
         2'd1:    r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

   lcv_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   lcv_root u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (root_rad),
      .done     (root_done),
      .root     (root_len)
   );

   lcv_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mag_ff[dsel][SCL_W-1:0]),
      .den   (root_len),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_ready     = (state_ff == S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_col0      = rsp_col_ff[0];
   assign rsp_col1      = rsp_col_ff[1];
   assign rsp_col2      = rsp_col_ff[2];
   assign rsp_col3      = rsp_col_ff[3];
   assign rsp_last_row  = rsp_last_ff;

   assign last_step = (kind_ff == K_CROSS) ? 3'd6 : 3'd3;
   assign jstep     = step_ff - 3'd1;
   assign ci_raw    = (kind_ff == K_CROSS) ? step_ff[2:1] : step_ff[1:0];
   assign ci        = (ci_raw == 2'd3) ? 2'd0 : ci_raw;
   assign cj        = (kind_ff == K_CROSS) ? jstep[2:1] : jstep[1:0];
   assign nx1       = next1(ci);
   assign nx2       = next2(ci);
   assign pr        = mul_p[ACC_W-1:0];
   assign cv        = neg_ff ? (acc_ff + pr) : (acc_ff - pr);
   assign fac       = (op_ff == OP_FWD) ? (F_W'(ONE) - $signed(F_W'(rate_ff)))
                                        : (F_W'(ONE) + $signed(F_W'(rate_ff)));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (kind_ff)
         K_CROSS: begin
            if (!step_ff[0]) begin
               mul_a = MUL_A_W'(n_ff[nx1]);
               mul_b = (dst_ff == D_V) ? MUL_B_W'(u_ff[nx2]) : up_ff[nx2];
            end else begin
               mul_a = MUL_A_W'(n_ff[nx2]);
               mul_b = (dst_ff == D_V) ? MUL_B_W'(u_ff[nx1]) : up_ff[nx1];
            end
         end
         K_SQ: begin
            mul_a = $signed(MUL_A_W'(mag_ff[ci][SCL_W-1:0]));
            mul_b = $signed(MUL_B_W'(mag_ff[ci][SCL_W-1:0]));
         end
         K_DOT: begin
            case (row_ff)
               2'd0:    mul_a = MUL_A_W'(u_ff[ci]);
               2'd1:    mul_a = MUL_A_W'(v_ff[ci]);
               default: mul_a = MUL_A_W'(n_ff[ci]);
            endcase
            mul_b = pos_ff[ci];
         end
         K_MOVE: begin
            mul_a = MUL_A_W'(fac);
            mul_b = pos_ff[ci];
         end
         K_STRAFE: begin
            mul_a = MUL_A_W'(vec_ff[ci] >>> FRAC_BITS);
            mul_b = $signed(MUL_B_W'(gain_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      kind_in      = kind_ff;
      dst_in       = dst_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      didx_in      = didx_ff;
      rate_in      = rate_ff;
      gain_in      = gain_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      root_start   = 1'b0;
      root_rad     = '0;
      div_start    = 1'b0;
      dsel         = 2'd0;
      ax_we        = 1'b0;
      ax_clr       = 1'b0;
      ax_val       = '0;
      big          = '0;
      for (int i = 0; i < 3; i++) begin
         pos_in[i] = pos_ff[i];
         tgt_in[i] = tgt_ff[i];
         up_in[i]  = up_ff[i];
         vec_in[i] = vec_ff[i];
         mag_in[i] = mag_ff[i];
         sgn_in[i] = sgn_ff[i];
         n_in[i]   = n_ff[i];
         u_in[i]   = u_ff[i];
         v_in[i]   = v_ff[i];
      end
      for (int i = 0; i < 4; i++) begin
         rsp_col_in[i] = rsp_col_ff[i];
      end

      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_TARGET_X: tgt_in[0] = csr_wdata;
            REG_TARGET_Y: tgt_in[1] = csr_wdata;
            REG_TARGET_Z: tgt_in[2] = csr_wdata;
            REG_UP_X:     up_in[0]  = csr_wdata;
            REG_UP_Y:     up_in[1]  = csr_wdata;
            REG_UP_Z:     up_in[2]  = csr_wdata;
            REG_RATE:     rate_in   = csr_wdata[RATE_W-1:0];
            REG_GAIN:     gain_in   = csr_wdata[GAIN_W-1:0];
            default:      rate_in   = rate_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = op_type'(req_op);
               unique case (op_type'(req_op))
                  OP_SET: begin
                     pos_in[0] = req_pos_x;
                     pos_in[1] = req_pos_y;
                     pos_in[2] = req_pos_z;
                  end
                  OP_GET, OP_LEFT, OP_RIGHT: begin
                     state_in = S_DIFF;
                  end
                  OP_FWD, OP_BWD: begin
                     kind_in  = K_MOVE;
                     step_in  = 3'd0;
                     state_in = S_MAC;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               vec_in[i] = VEC_W'(pos_ff[i]) - VEC_W'(tgt_ff[i]);
            end
            dst_in   = D_N;
            state_in = S_ABS;
         end
         S_ABS: begin
            for (int i = 0; i < 3; i++) begin
               sgn_in[i] = vec_ff[i][VEC_W-1];
               mag_in[i] = vec_ff[i][VEC_W-1] ? VEC_W'(-vec_ff[i]) : VEC_W'(vec_ff[i]);
            end
            state_in = S_SCALE;
         end
         S_SCALE: begin
            big = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
            big = (mag_ff[2] > big) ? mag_ff[2] : big;
            if (big == '0) begin
               ax_clr   = 1'b1;
               state_in = S_NEXT;
            end else if (|big[VEC_W-1:SCL_W]) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
            end else if (!big[SCL_W-1]) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] << 1;
               end
            end else begin
               kind_in  = K_SQ;
               step_in  = 3'd0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            if (step_ff != 3'd0) begin
               case (kind_ff)
                  K_CROSS: begin
                     if (!jstep[0]) begin
                        acc_in = neg_ff ? -pr : pr;
                     end else begin
                        vec_in[cj] = cv[VEC_W-1:0];
                     end
                  end
                  K_SQ, K_DOT: begin
                     acc_in = ((step_ff == 3'd1) ? '0 : acc_ff) + pr;
                  end
                  K_MOVE: begin
                     pos_in[cj] = sat32(pr >>> FRAC_BITS);
                  end
                  K_STRAFE: begin
                     pos_in[cj] = sat32(ACC_W'(pos_ff[cj]) + (pr >>> FRAC_BITS));
                  end
                  default: acc_in = acc_ff;
               endcase
            end
            if (step_ff == last_step) begin
               step_in = 3'd0;
               case (kind_ff)
                  K_CROSS: begin
                     if (op_ff == OP_GET) begin
                        state_in = S_ABS;
                     end else begin
                        kind_in = K_STRAFE;
                     end
                  end
                  K_SQ: begin
                     root_start = 1'b1;
                     root_rad   = acc_in[RAD_W-1:0];
                     state_in   = S_ROOT;
                  end
                  K_DOT:   state_in = S_OUT;
                  default: state_in = S_IDLE;
               endcase
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_ROOT: begin
            if (root_done) begin
               div_start = 1'b1;
               dsel      = 2'd0;
               didx_in   = 2'd0;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            dsel = didx_ff + 2'd1;
            if (div_done) begin
               ax_we  = 1'b1;
               ax_val = sgn_ff[didx_ff] ? -AX_W'(div_quo) : AX_W'(div_quo);
               if (didx_ff == 2'd2) begin
                  state_in = S_NEXT;
               end else begin
                  div_start = 1'b1;
                  didx_in   = didx_ff + 2'd1;
               end
            end
         end
         S_NEXT: begin
            kind_in  = K_CROSS;
            step_in  = 3'd0;
            state_in = S_MAC;
            unique case (dst_ff)
               D_N: begin
                  if (op_ff == OP_GET) begin
                     dst_in = D_U;
                     neg_in = 1'b1;
                  end else begin
                     neg_in = (op_ff == OP_RIGHT);
                  end
               end
               D_U: begin
                  dst_in = D_V;
                  neg_in = 1'b0;
               end
               D_V: begin
                  kind_in = K_DOT;
                  row_in  = 2'd0;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_last_in  = (row_ff == 2'd2);
               for (int i = 0; i < 3; i++) begin
                  case (row_ff)
                     2'd0:    rsp_col_in[i] = POS_W'(u_ff[i]);
                     2'd1:    rsp_col_in[i] = POS_W'(v_ff[i]);
                     default: rsp_col_in[i] = POS_W'(n_ff[i]);
                  endcase
               end
               rsp_col_in[3] = sat32((-acc_ff) >>> FRAC_BITS);
               if (row_ff == 2'd2) begin
                  state_in = S_IDLE;
               end else begin
                  row_in   = row_ff + 2'd1;
                  kind_in  = K_DOT;
                  step_in  = 3'd0;
                  state_in = S_MAC;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (ax_we || ax_clr) begin
         for (int i = 0; i < 3; i++) begin
            if (ax_clr || (didx_ff == 2'(i))) begin
               case (dst_ff)
                  D_N:     n_in[i] = ax_clr ? '0 : ax_val;
                  D_U:     u_in[i] = ax_clr ? '0 : ax_val;
                  default: v_in[i] = ax_clr ? '0 : ax_val;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= RATE_W'(RATE_RST);
         gain_ff      <= GAIN_W'(GAIN_RST);
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            tgt_ff[i] <= '0;
            up_ff[i]  <= (i == 1) ? POS_W'(ONE) : '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_ff      <= rate_in;
         gain_ff      <= gain_in;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= pos_in[i];
            tgt_ff[i] <= tgt_in[i];
            up_ff[i]  <= up_in[i];
         end
      end
      op_ff       <= op_in;
      kind_ff     <= kind_in;
      dst_ff      <= dst_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      row_ff      <= row_in;
      didx_ff     <= didx_in;
      acc_ff      <= acc_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
      for (int i = 0; i < 3; i++) begin
         vec_ff[i] <= vec_in[i];
         mag_ff[i] <= mag_in[i];
         sgn_ff[i] <= sgn_in[i];
         n_ff[i]   <= n_in[i];
         u_ff[i]   <= u_in[i];
         v_ff[i]   <= v_in[i];
      end
      for (int i = 0; i < 4; i++) begin
         rsp_col_ff[i] <= rsp_col_in[i];
      end
   end

endmodule
`default_nettype wire

### bench/lookat_camera_view_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Look-at camera view unit testbench
// Drives camera operations through random gaps and stalls, predicts every
// view matrix row in fixed point and compares each returned row in turn.
// ----------------------------------------------------------------------------
module lookat_camera_view_unit_tb;
   import lcv_pkg::*;

   typedef struct {
      logic [OP_W-1:0]         op;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } cam_cmd_type;

   typedef struct {
      logic [ROW_W-1:0]        row;
      logic signed [POS_W-1:0] c0;
      logic signed [POS_W-1:0] c1;
      logic signed [POS_W-1:0] c2;
      logic signed [POS_W-1:0] c3;
      logic                    last;
   } view_row_type;

   typedef longint vec3_type [3];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0] req_op = '0;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic signed [POS_W-1:0] req_pos_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ROW_W-1:0] rsp_row_index;
   logic signed [POS_W-1:0] rsp_col0, rsp_col1, rsp_col2, rsp_col3;
   logic rsp_last_row;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   cam_cmd_type  pending_cmds [$];
   view_row_type expected_rows [$];
   cam_cmd_type  cur_cmd;
   bit        cmd_taken = 0;
   bit        row_taken = 0;
   bit        calm = 0;
   int        cmd_gap = 0;
   int        row_stall = 0;
   int        fails = 0;
   longint    cycles = 0;

   longint tgt [3];
   longint upv [3];
   longint cam [3];
   longint rate, gain;

   lookat_camera_view_unit u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   task automatic unit_vec(input vec3_type v, output vec3_type o);
      longint unsigned m [3];
      longint unsigned big, sum, len, q;
      int r, l;
      big = 0;
      sum = 0;
      r = 0;
      l = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (v[i] < 0) ? -v[i] : v[i];
         if (m[i] > big) big = m[i];
      end
      if (big == 0) begin
         o[0] = 0; o[1] = 0; o[2] = 0;
      end else begin
         while ((big >> r) >= (64'd1 << 30)) r++;
         if (r == 0) while ((big << l) < (64'd1 << 29)) l++;
         for (int i = 0; i < 3; i++) begin
            m[i] = (m[i] >> r) << l;
            sum = sum + m[i] * m[i];
         end
         len = root64(sum);
         for (int i = 0; i < 3; i++) begin
            q = (m[i] << FRAC_BITS) / len;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
         end
      end
   endtask

   task automatic cross_prod(input vec3_type a, input vec3_type b, output vec3_type r);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endtask

   task automatic look_dir(output vec3_type n);
      vec3_type d;
      for (int i = 0; i < 3; i++) d[i] = cam[i] - tgt[i];
      unit_vec(d, n);
   endtask

   task automatic apply_camera_cmd(input cam_cmd_type c);
      vec3_type n, w, ax0, ax1, ax2, cur;
      vec3_type axes [3];
      longint f, dot;
      view_row_type vr;
      case (c.op)
         OP_SET: begin
            cam[0] = longint'(c.x); cam[1] = longint'(c.y); cam[2] = longint'(c.z);
         end
         OP_GET: begin
            look_dir(n);
            cross_prod(upv, n, w);
            unit_vec(w, ax0);
            cross_prod(n, ax0, w);
            unit_vec(w, ax1);
            axes[0] = ax0; axes[1] = ax1; axes[2] = n;
            for (int k = 0; k < 3; k++) begin
               cur = axes[k];
               dot = 0;
               for (int i = 0; i < 3; i++) dot = dot + cur[i] * cam[i];
               vr.row = ROW_W'(k);
               vr.c0 = cur[0][31:0];
               vr.c1 = cur[1][31:0];
               vr.c2 = cur[2][31:0];
               vr.c3 = 32'(clip32((-dot) >>> FRAC_BITS));
               vr.last = (k == 2);
               expected_rows.push_back(vr);
            end
         end
         OP_FWD, OP_BWD: begin
            f = ONE + ((c.op == OP_FWD) ? -rate : rate);
            for (int i = 0; i < 3; i++) cam[i] = clip32((cam[i] * f) >>> FRAC_BITS);
         end
         OP_LEFT, OP_RIGHT: begin
            look_dir(n);
            if (c.op == OP_LEFT) cross_prod(n, upv, w);
            else cross_prod(upv, n, w);
            for (int i = 0; i < 3; i++)
               cam[i] = clip32(cam[i] + ((((w[i] >>> FRAC_BITS)) * gain) >>> FRAC_BITS));
         end
         default: ;
      endcase
   endtask

   task automatic report(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
      fails++;
   endtask

   always @(posedge clock) begin
      view_row_type e;
      cycles++;
      if (cycles > 64'd2000000) begin
         $display("Some tests failed");
         $finish;
      end else begin
         if (!reset && req_valid && req_ready) begin
            apply_camera_cmd(cur_cmd);
            cmd_taken = 1;
         end
         if (!reset && rsp_valid && rsp_ready) begin
            row_taken = 1;
            if (expected_rows.size() == 0) begin
               report("unexpected row", rsp_row_index, -1);
            end else begin
               e = expected_rows.pop_front();
               if (rsp_row_index !== e.row) report("row_index", rsp_row_index, e.row);
               if (rsp_col0 !== e.c0) report("col0", rsp_col0, e.c0);
               if (rsp_col1 !== e.c1) report("col1", rsp_col1, e.c1);
               if (rsp_col2 !== e.c2) report("col2", rsp_col2, e.c2);
               if (rsp_col3 !== e.c3) report("col3", rsp_col3, e.c3);
               if (rsp_last_row !== e.last) report("last_row", rsp_last_row, e.last);
            end
         end
      end
   end

   always @(negedge clock) begin
      logic nv;
      nv = req_valid;
      if (cmd_taken) begin
         nv = 1'b0;
         cmd_taken = 0;
      end
      if (!nv && !reset) begin
         if (cmd_gap > 0) begin
            cmd_gap--;
         end else if (pending_cmds.size() > 0) begin
            cur_cmd = pending_cmds.pop_front();
            nv = 1'b1;
            req_op <= cur_cmd.op;
            req_pos_x <= cur_cmd.x;
            req_pos_y <= cur_cmd.y;
            req_pos_z <= cur_cmd.z;
            cmd_gap = calm ? 0 : $urandom_range(0, 12);
         end
      end
      req_valid <= nv;
   end

   always @(negedge clock) begin
      if (row_taken) begin
         row_taken = 0;
         row_stall = calm ? 0 : $urandom_range(0, 12);
      end
      if (row_stall > 0) begin
         row_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic write_reg(input csr_reg_type idx, input logic [31:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_TARGET_X: tgt[0] = longint'($signed(d));
         REG_TARGET_Y: tgt[1] = longint'($signed(d));
         REG_TARGET_Z: tgt[2] = longint'($signed(d));
         REG_UP_X:     upv[0] = longint'($signed(d));
         REG_UP_Y:     upv[1] = longint'($signed(d));
         REG_UP_Z:     upv[2] = longint'($signed(d));
         REG_RATE:     rate = longint'(d[RATE_W-1:0]);
         REG_GAIN:     gain = longint'(d[GAIN_W-1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain(input int tail);
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_rows.size() != 0);
      repeat (tail) @(posedge clock);
   endtask

   task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
      cam_cmd_type c;
      c.op = op; c.x = x; c.y = y; c.z = z;
      pending_cmds.push_back(c);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
         2: return 32'($signed($urandom_range(0, 2 << 24)) - (1 << 24));
         3: return 32'd0;
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_random(input int count);
      int w;
      for (int i = 0; i < count; i++) begin
         w = $urandom_range(0, 99);
         if (w < 30) queue_cmd(OP_GET, $urandom(), $urandom(), $urandom());
         else if (w < 50) queue_cmd(OP_SET, rand_coord(), rand_coord(), rand_coord());
         else if (w < 60) queue_cmd(OP_FWD, $urandom(), $urandom(), $urandom());
         else if (w < 70) queue_cmd(OP_BWD, $urandom(), $urandom(), $urandom());
         else if (w < 82) queue_cmd(OP_LEFT, $urandom(), $urandom(), $urandom());
         else if (w < 95) queue_cmd(OP_RIGHT, $urandom(), $urandom(), $urandom());
         else queue_cmd(OP_W'($urandom_range(6, 7)), $urandom(), $urandom(), $urandom());
      end
   endtask

   initial begin
      tgt = '{0, 0, 0};
      upv = '{0, ONE, 0};
      cam = '{0, 0, 0};
      rate = longint'(RATE_RST);
      gain = longint'(GAIN_RST);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      calm = 1;
      queue_cmd(OP_GET, 0, 0, 0);
      queue_cmd(OP_SET, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      queue_cmd(OP_GET, 0, 0, 0);
      queue_cmd(OP_FWD, 0, 0, 0);
      queue_cmd(OP_BWD, 0, 0, 0);
      queue_cmd(OP_LEFT, 0, 0, 0);
      queue_cmd(OP_RIGHT, 0, 0, 0);
      queue_cmd(OP_GET, 0, 0, 0);
      queue_cmd(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_cmd(3'd7, 32'h1234_5678, 0, 0);
      queue_cmd(OP_GET, 0, 0, 0);
      queue_cmd(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_cmd(OP_GET, 0, 0, 0);
      queue_cmd(OP_BWD, 0, 0, 0);
      queue_cmd(OP_RIGHT, 0, 0, 0);
      queue_cmd(OP_GET, 0, 0, 0);
      queue_cmd(OP_SET, 0, 32'h0005_0000, 0);
      queue_cmd(OP_GET, 0, 0, 0);
      queue_cmd(OP_LEFT, 0, 0, 0);
      queue_cmd(OP_SET, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      queue_cmd(OP_GET, 0, 0, 0);
      queue_cmd(OP_FWD, 0, 0, 0);
      queue_cmd(OP_GET, 0, 0, 0);
      drain(0);
      calm = 0;
      queue_random(60);
      drain(500);

      write_reg(REG_TARGET_X, rand_coord());
      write_reg(REG_TARGET_Y, rand_coord());
      write_reg(REG_TARGET_Z, rand_coord());
      write_reg(REG_UP_X, $urandom_range(0, 2 * ONE) - ONE);
      write_reg(REG_UP_Y, $urandom_range(0, 2 * ONE) - ONE);
      write_reg(REG_UP_Z, $urandom_range(0, 2 * ONE) - ONE);
      write_reg(REG_RATE, $urandom_range(0, ONE));
      write_reg(REG_GAIN, $urandom_range(0, 1 << 24));
      queue_random(35);
      drain(0);
      queue_random(30);
      drain(500);

      write_reg(REG_TARGET_X, 32'h7FFF_FFFF);
      write_reg(REG_TARGET_Y, 32'h8000_0000);
      write_reg(REG_TARGET_Z, 32'h7FFF_FFFF);
      write_reg(REG_UP_X, 32'h8000_0000);
      write_reg(REG_UP_Y, 32'h7FFF_FFFF);
      write_reg(REG_UP_Z, 32'h8000_0000);
      write_reg(REG_RATE, 0);
      write_reg(REG_GAIN, 32'h01FF_FFFF);
      queue_random(65);
      drain(500);

      calm = 1;
      write_reg(REG_TARGET_X, 0);
      write_reg(REG_TARGET_Y, 0);
      write_reg(REG_TARGET_Z, 0);
      write_reg(REG_UP_X, 0);
      write_reg(REG_UP_Y, 0);
      write_reg(REG_UP_Z, 0);
      write_reg(REG_RATE, ONE);
      write_reg(REG_GAIN, 0);
      queue_random(60);
      drain(500);

      calm = 0;
      write_reg(REG_UP_Y, ONE);
      write_reg(REG_RATE, 32'hFFFF_FFFF);
      write_reg(REG_GAIN, 32'hFFFF_FFFF);
      queue_random(65);
      drain(500);

      write_reg(REG_TARGET_X, $urandom());
      write_reg(REG_TARGET_Y, $urandom());
      write_reg(REG_TARGET_Z, $urandom());
      write_reg(REG_UP_X, $urandom());
      write_reg(REG_UP_Y, $urandom());
      write_reg(REG_UP_Z, $urandom());
      write_reg(REG_RATE, $urandom());
      write_reg(REG_GAIN, $urandom());
      queue_random(70);
      drain(500);

      if (fails == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/lcv_pkg.sv
rtl/core/lcv_mul.sv
rtl/core/lcv_root.sv
rtl/core/lcv_div.sv
rtl/core/lookat_camera_view_unit.sv
bench/lookat_camera_view_unit_tb.sv
